// ----- design/lcs_pkg.sv -----
`default_nettype none
// ============================================================================
// lcs_pkg - shared types and constants of the line comment stripper
// Character codes and the result record passed from the lexer to the queue.
// ============================================================================
package lcs_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] count;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       last;
    } result_t;

endpackage
`default_nettype wire

// ----- design/lcs_lexer.sv -----
`default_nettype none
// ============================================================================
// lcs_lexer - lexer mode machine of the line comment stripper
// Classifies each request byte and forms the zero, one or two output bytes.
// ============================================================================
module lcs_lexer
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       in_byte,
    input  wire logic             in_last,
    output lcs_pkg::result_t      res
);
    import lcs_pkg::*;

    localparam logic [2:0] M_CODE    = 3'd0;
    localparam logic [2:0] M_OPEN    = 3'd1;
    localparam logic [2:0] M_STR     = 3'd2;
    localparam logic [2:0] M_ESC     = 3'd3;
    localparam logic [2:0] M_TRIPLE  = 3'd4;
    localparam logic [2:0] M_COMMENT = 3'd5;

    logic [2:0] mode_reg, mode_next;
    logic [1:0] qrun_reg, qrun_next;
    logic       dash_reg, dash_next;

    always_comb
    begin
        logic       do_code;
        logic [1:0] n;
        logic [7:0] b0;
        logic [7:0] b1;
        do_code   = 1'b0;
        n         = 2'd0;
        b0        = CH_SPACE;
        b1        = CH_SPACE;
        mode_next = mode_reg;
        qrun_next = qrun_reg;
        dash_next = 1'b0;

        if (dash_reg)
        begin
            if (in_byte == CH_DASH)
            begin
                b0        = CH_SPACE;
                b1        = CH_SPACE;
                n         = 2'd2;
                mode_next = M_COMMENT;
            end
            else
            begin
                b0      = CH_DASH;
                n       = 2'd1;
                do_code = 1'b1;
            end
        end
        else
        begin
            case (mode_reg)
                M_OPEN:
                begin
                    if (qrun_reg >= 2'd2)
                    begin
                        qrun_next = 2'd0;
                        if (in_byte == CH_QUOTE)
                        begin
                            mode_next = M_TRIPLE;
                            b0        = in_byte;
                            n         = 2'd1;
                        end
                        else
                        begin
                            mode_next = M_CODE;
                            do_code   = 1'b1;
                        end
                    end
                    else
                    begin
                        b0 = in_byte;
                        n  = 2'd1;
                        if (in_byte == CH_QUOTE)
                        begin
                            qrun_next = 2'd2;
                        end
                        else
                        begin
                            qrun_next = 2'd0;
                            mode_next = (in_byte == CH_BSLASH) ? M_ESC : M_STR;
                        end
                    end
                end
                M_STR:
                begin
                    b0 = in_byte;
                    n  = 2'd1;
                    if (in_byte == CH_BSLASH)
                    begin
                        mode_next = M_ESC;
                    end
                    else if (in_byte == CH_QUOTE)
                    begin
                        mode_next = M_CODE;
                    end
                end
                M_ESC:
                begin
                    b0        = in_byte;
                    n         = 2'd1;
                    mode_next = M_STR;
                end
                M_TRIPLE:
                begin
                    b0 = in_byte;
                    n  = 2'd1;
                    if (in_byte == CH_QUOTE)
                    begin
                        if (qrun_reg >= 2'd2)
                        begin
                            qrun_next = 2'd0;
                            mode_next = M_CODE;
                        end
                        else
                        begin
                            qrun_next = qrun_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        qrun_next = 2'd0;
                    end
                end
                M_COMMENT:
                begin
                    n = 2'd1;
                    if (in_byte == CH_NL)
                    begin
                        b0        = in_byte;
                        mode_next = M_CODE;
                    end
                    else
                    begin
                        b0 = CH_SPACE;
                    end
                end
                default:
                begin
                    mode_next = M_CODE;
                    do_code   = 1'b1;
                end
            endcase
        end

        if (do_code)
        begin
            if (in_byte == CH_DASH)
            begin
                dash_next = 1'b1;
            end
            else
            begin
                if (in_byte == CH_QUOTE)
                begin
                    mode_next = M_OPEN;
                    qrun_next = 2'd1;
                end
                if (n == 2'd0)
                begin
                    b0 = in_byte;
                end
                else
                begin
                    b1 = in_byte;
                end
                n = n + 2'd1;
            end
        end

        if (in_last)
        begin
            if (dash_next)
            begin
                if (n == 2'd0)
                begin
                    b0 = CH_DASH;
                end
                else
                begin
                    b1 = CH_DASH;
                end
                n = n + 2'd1;
            end
            mode_next = M_CODE;
            qrun_next = 2'd0;
            dash_next = 1'b0;
        end

        res.count = n;
        res.byte0 = b0;
        res.byte1 = b1;
        res.last  = in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_CODE;
            qrun_reg <= 2'd0;
            dash_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            qrun_reg <= qrun_next;
            dash_reg <= dash_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/line_comment_stripper.sv -----
`default_nettype none
// ============================================================================
// line_comment_stripper - string aware double-dash comment stripper
// Replaces line comments with spaces, keeping strings and byte count intact.
// ============================================================================
// The block takes one byte per cycle on the slave stream and returns the same
// number of bytes on the master stream. A byte is classified in the cycle it
// is accepted, and its zero, one or two output bytes enter a four-entry output
// queue; a byte is accepted whenever the queue has room for two entries, so
// with the master side always ready the sustained rate is one byte per cycle.
// A dash in code is held until the next byte; the byte marked by tlast
// flushes it and returns the lexer to code mode.
module line_comment_stripper
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output      logic       s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // in_last
    output      logic       m_tvalid,
    input  wire logic       m_tready,
    output      logic [7:0] m_tdata,   // [7:0] out_byte
    output      logic       m_tlast    // out_last
);
    import lcs_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    result_t res;
    logic    accept;
    logic    pop;

    logic [7:0]    qbyte_reg [QUEUE_DEPTH];
    logic          qlast_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_next;

    assign s_tready = (count_reg <= CW'(QUEUE_DEPTH - 2));
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = qbyte_reg[rd_reg];
    assign m_tlast  = qlast_reg[rd_reg];

    lcs_lexer u_lexer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .res     (res)
    );

    always_comb
    begin
        wr_next    = wr_reg;
        count_next = count_reg;
        if (accept)
        begin
            wr_next    = wr_reg + PW'(res.count);
            count_next = count_next + CW'(res.count);
        end
        if (pop)
        begin
            count_next = count_next - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (res.count != 2'd0))
        begin
            qbyte_reg[wr_reg] <= res.byte0;
            qlast_reg[wr_reg] <= res.last && (res.count == 2'd1);
            if (res.count == 2'd2)
            begin
                qbyte_reg[wr_reg + PW'(1)] <= res.byte1;
                qlast_reg[wr_reg + PW'(1)] <= res.last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            count_reg <= count_next;
            if (pop)
            begin
                rd_reg <= rd_reg + PW'(1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("output queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |-> (res.count != 2'd0))
        else $error("last request produced no output");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tdata != CH_DASH)) |-> (res.count != 2'd0))
        else $error("non-dash request produced no output");

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb - testbench of the line comment stripper
// Streams directed and random source texts through the block, predicts every
// output byte from its own lexer model and checks each result request in
// order, under several patterns of sender idling and receiver stalls.
// ============================================================================
module tb;
    import lcs_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_ITEMS  = 125;

    typedef enum logic [2:0] {
        LX_CODE,
        LX_OPEN,
        LX_STR,
        LX_ESC,
        LX_TRIPLE,
        LX_COMMENT
    } lex_mode_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_req_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_tlast  = 1'b0;    // in_last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tlast;            // out_last

    text_req_t   source_q[$];
    text_req_t   stripped_q[$];
    logic [7:0]  text_q[$];
    text_req_t   next_src;
    text_req_t   want;

    lex_mode_e   mode_q;
    logic [1:0]  quote_cnt;
    logic        dash_wait;
    logic [7:0]  emit_buf [0:2];
    int          emit_cnt;

    int send_idle  = 0;
    int recv_stall = 0;
    int errors     = 0;
    int cycles     = 0;
    int texts      = 0;
    int items_queued = 0;
    int bytes_in   = 0;
    int bytes_out  = 0;

    line_comment_stripper u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    task automatic emit_byte(input logic [7:0] b);
        emit_buf[emit_cnt] = b;
        emit_cnt++;
    endtask

    task automatic lex_code(input logic [7:0] b);
        if (b == CH_QUOTE)
        begin
            mode_q    = LX_OPEN;
            quote_cnt = 2'd1;
            emit_byte(b);
        end
        else if (b == CH_DASH)
            dash_wait = 1'b1;
        else
            emit_byte(b);
    endtask

    task automatic strip_predict(input logic [7:0] b, input logic last);
        int k;
        text_req_t rec;
        emit_cnt = 0;
        if (dash_wait)
        begin
            dash_wait = 1'b0;
            if (b == CH_DASH)
            begin
                emit_byte(CH_SPACE);
                emit_byte(CH_SPACE);
                mode_q = LX_COMMENT;
            end
            else
            begin
                emit_byte(CH_DASH);
                lex_code(b);
            end
        end
        else
        begin
            case (mode_q)
                LX_OPEN:
                begin
                    if (quote_cnt >= 2'd2)
                    begin
                        quote_cnt = 2'd0;
                        if (b == CH_QUOTE)
                        begin
                            mode_q = LX_TRIPLE;
                            emit_byte(b);
                        end
                        else
                        begin
                            mode_q = LX_CODE;
                            lex_code(b);
                        end
                    end
                    else
                    begin
                        emit_byte(b);
                        if (b == CH_QUOTE)
                            quote_cnt = 2'd2;
                        else
                        begin
                            quote_cnt = 2'd0;
                            mode_q = (b == CH_BSLASH) ? LX_ESC : LX_STR;
                        end
                    end
                end
                LX_STR:
                begin
                    emit_byte(b);
                    if (b == CH_BSLASH)
                        mode_q = LX_ESC;
                    else if (b == CH_QUOTE)
                        mode_q = LX_CODE;
                end
                LX_ESC:
                begin
                    emit_byte(b);
                    mode_q = LX_STR;
                end
                LX_TRIPLE:
                begin
                    emit_byte(b);
                    if (b != CH_QUOTE)
                        quote_cnt = 2'd0;
                    else if (quote_cnt == 2'd2)
                    begin
                        quote_cnt = 2'd0;
                        mode_q = LX_CODE;
                    end
                    else
                        quote_cnt = quote_cnt + 2'd1;
                end
                LX_COMMENT:
                begin
                    if (b == CH_NL)
                    begin
                        emit_byte(b);
                        mode_q = LX_CODE;
                    end
                    else
                        emit_byte(CH_SPACE);
                end
                default:
                begin
                    mode_q = LX_CODE;
                    lex_code(b);
                end
            endcase
        end
        if (last)
        begin
            if (dash_wait)
                emit_byte(CH_DASH);
            mode_q    = LX_CODE;
            quote_cnt = 2'd0;
            dash_wait = 1'b0;
        end
        for (k = 0; k < emit_cnt; k++)
        begin
            rec.data = emit_buf[k];
            rec.last = last && (k == emit_cnt - 1);
            stripped_q.push_back(rec);
        end
    endtask

    task automatic push_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic end_text();
        text_req_t rec;
        while (text_q.size() > 0)
        begin
            rec.data = text_q.pop_front();
            rec.last = (text_q.size() == 0);
            source_q.push_back(rec);
            items_queued++;
        end
        texts++;
    endtask

    function automatic logic [7:0] byte_but(input logic [7:0] avoid);
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == avoid) ? 8'h41 : b;
    endfunction

    task automatic random_text();
        int frags;
        int k;
        int j;
        int len;
        frags = $urandom_range(1, 8);
        for (k = 0; k < frags; k++)
        begin
            len = $urandom_range(0, 6);
            case ($urandom_range(9))
                0, 1, 2:
                    for (j = 0; j <= len; j++)
                        text_q.push_back(8'($urandom_range(8'h30, 8'h7A)));
                3:
                    case ($urandom_range(2))
                        0: text_q.push_back(CH_SPACE);
                        1: text_q.push_back(CH_NL);
                        default: text_q.push_back(8'h09);
                    endcase
                4:
                begin
                    push_str("--");
                    for (j = 0; j < len; j++)
                        text_q.push_back(8'($urandom_range(255)));
                    if ($urandom_range(4) != 0)
                        text_q.push_back(CH_NL);
                end
                5:
                begin
                    text_q.push_back(CH_QUOTE);
                    for (j = 0; j < len; j++)
                    begin
                        if ($urandom_range(3) == 0)
                        begin
                            text_q.push_back(CH_BSLASH);
                            text_q.push_back(8'($urandom_range(255)));
                        end
                        else if ($urandom_range(3) == 0)
                            text_q.push_back(CH_DASH);
                        else
                            text_q.push_back(byte_but(CH_QUOTE));
                    end
                    text_q.push_back(CH_QUOTE);
                end
                6:
                begin
                    push_str("\"\"\"");
                    for (j = 0; j < len; j++)
                    begin
                        if ($urandom_range(3) == 0)
                        begin
                            text_q.push_back(CH_QUOTE);
                            if ($urandom_range(1) == 0)
                                text_q.push_back(CH_QUOTE);
                            text_q.push_back(byte_but(CH_QUOTE));
                        end
                        else if ($urandom_range(3) == 0)
                            push_str("--");
                        else
                            text_q.push_back(byte_but(CH_QUOTE));
                    end
                    push_str("\"\"\"");
                    if ($urandom_range(4) == 0)
                        text_q.push_back(CH_QUOTE);
                end
                7:
                begin
                    text_q.push_back(CH_DASH);
                    case ($urandom_range(3))
                        0: text_q.push_back(CH_QUOTE);
                        1: text_q.push_back(CH_NL);
                        2: text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
                        default: text_q.push_back(8'($urandom_range(255)));
                    endcase
                end
                8:
                    text_q.push_back(8'($urandom_range(255)));
                default:
                    case ($urandom_range(4))
                        0: text_q.push_back(CH_QUOTE);
                        1: text_q.push_back(CH_BSLASH);
                        2: push_str("\"\"");
                        3: text_q.push_back(CH_DASH);
                        default: push_str("\"\"\"");
                    endcase
            endcase
        end
        end_text();
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, stripped_q.size());
            $display("tb failed");
            $finish;
        end
    end

    // driver: account the accepted request, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                strip_predict(s_tdata, s_tlast);
                bytes_in++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (source_q.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    next_src = source_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_src.data;
                    s_tlast  <= next_src.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check each result request against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                bytes_out++;
                if (stripped_q.size() == 0)
                begin
                    $display("%0t: unexpected result data %02h last %0b",
                             $time, m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    want = stripped_q.pop_front();
                    if (m_tdata !== want.data)
                    begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.data, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: out_last expected %0b actual %0b",
                                 $time, want.last, m_tlast);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    initial
    begin
        int ph;
        int target;
        mode_q    = LX_CODE;
        quote_cnt = 2'd0;
        dash_wait = 1'b0;
        emit_cnt  = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // zero and all-ones bytes, held dash flushed by the last byte
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        text_q.push_back(CH_DASH);
        end_text();
        // comment up to newline, then a lone dash before a letter
        push_str("--\n-q");
        end_text();
        // dashes and an escaped quote inside a string
        push_str("\"--\\\"\"");
        end_text();
        // empty string, then a comment opened on the last byte
        push_str("\"\"--");
        end_text();
        // triple string closed by a run of four quotes
        push_str("\"\"\"--\"\"\"\"");
        end_text();
        // backslash as the final byte inside a string
        push_str("\"\\");
        end_text();

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle  <= 0;
                    recv_stall <= 0;
                end
                1:
                begin
                    send_idle  <= 74;
                    recv_stall <= 0;
                end
                2:
                begin
                    send_idle  <= 0;
                    recv_stall <= 74;
                end
                default:
                begin
                    send_idle  <= 38;
                    recv_stall <= 38;
                end
            endcase
            target = items_queued + PHASE_ITEMS;
            while (items_queued < target)
                random_text();
            while (source_q.size() > 0)
                @(posedge clk);
        end

        while (source_q.size() > 0 || s_tvalid)
            @(posedge clk);
        while (stripped_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d texts: %0d bytes in, %0d bytes out", texts, bytes_in, bytes_out);
        $display("idle patterns: none, sender, receiver, both; %0d mismatches", errors);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
